// ===== rtl/ihex_pkg.sv =====
// Shared types, constants and helper functions of the Intel HEX record encoder.
// Used by the front end, the command queue and the character back end.
`timescale 1ns / 1ps

package ihex_pkg;

  // Line buffer geometry
  localparam int LINE_BYTES = 16;
  localparam int FILL_W     = $clog2(LINE_BYTES);
  localparam int CNT_W      = FILL_W + 1;

  // Input opcodes
  localparam logic [1:0] OP_DATA      = 2'd0;
  localparam logic [1:0] OP_START_SEG = 2'd1;
  localparam logic [1:0] OP_START_LIN = 2'd2;
  localparam logic [1:0] OP_EOF       = 2'd3;

  // Address modes
  localparam logic [1:0] MODE_16  = 2'd0;
  localparam logic [1:0] MODE_SEG = 2'd1;

  // Record types
  localparam logic [7:0] REC_DATA      = 8'h00;
  localparam logic [7:0] REC_EOF       = 8'h01;
  localparam logic [7:0] REC_EXT_SEG   = 8'h02;
  localparam logic [7:0] REC_START_SEG = 8'h03;
  localparam logic [7:0] REC_EXT_LIN   = 8'h04;
  localparam logic [7:0] REC_START_LIN = 8'h05;

  // Fixed characters
  localparam logic [7:0] CHR_COLON = 8'h3A;
  localparam logic [7:0] CHR_LF    = 8'h0A;
  localparam logic [7:0] CHR_ERR   = 8'h00;

  typedef logic [LINE_BYTES-1:0][7:0] line_t;

  // One record (or one error mark) for the back end to print
  typedef struct packed {
    logic             is_err;
    logic [7:0]       rtype;
    logic [15:0]      addr;
    logic [CNT_W-1:0] len;
    line_t            data;
    logic             last;
  } ihex_cmd_t;

  // Uppercase ASCII hex digit of a nibble
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = 8'h30 + {4'h0, nib};
    end else begin
      c = 8'h37 + {4'h0, nib};
    end
    return c;
  endfunction

endpackage

// ===== rtl/ihex_cmd_fifo.sv =====
// Two-entry command queue between the encoder front end and back end.
// Depends on ihex_pkg for the command struct.
`timescale 1ns / 1ps

module ihex_cmd_fifo
  import ihex_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  ihex_cmd_t push_cmd,
  output logic      full,
  input  logic      pop,
  output ihex_cmd_t head,
  output logic      empty
);

  ihex_cmd_t  mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;

  assign full  = (count_r == 2'd2);
  assign empty = (count_r == 2'd0);
  assign head  = mem_r[rd_ptr_r];

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push && !full) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop && !empty) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({push && !full, pop && !empty})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ===== rtl/ihex_front.sv =====
// Front end of the Intel HEX encoder: accepts items, keeps the line buffer,
// run and window state, and turns each item into record commands. Uses ihex_pkg.
`timescale 1ns / 1ps

module ihex_front
  import ihex_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_opcode,
  input  logic [7:0]  in_data_byte,
  input  logic [31:0] in_byte_address,
  input  logic        in_run_end,
  input  logic [31:0] in_start_address,
  output logic        q_push,
  output ihex_cmd_t   q_cmd,
  input  logic        q_full
);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_EVAL = 3'b010,
    F_PUSH = 3'b100
  } front_state_t;

  front_state_t state_r, state_nxt;

  // Latched item
  logic [1:0]  it_op_r;
  logic [7:0]  it_byte_r;
  logic [31:0] it_addr_r;
  logic        it_end_r;
  logic [31:0] it_start_r;

  // Encoder state
  logic [1:0]        mode_r;
  line_t             line_bytes_r;
  logic [FILL_W-1:0] line_fill_r, line_fill_nxt;
  logic [15:0]       line_start_r, line_start_nxt;
  logic [32:0]       next_addr_r, next_addr_nxt;
  logic [15:0]       window_r, window_nxt;
  logic              within_run_r, within_run_nxt;
  logic              buf_we;

  // Pending commands of the current item
  ihex_cmd_t cmd_r [2];
  ihex_cmd_t cmd0_c, cmd1_c;
  logic [1:0] ncmd_r, ncmd_c;
  logic       idx_r, idx_nxt;

  // Decode helpers
  logic [32:0]      addr_c;
  logic             over_c;
  logic             fresh_c;
  logic             ext_c;
  logic             flush_c;
  logic [15:0]      win_c;
  logic [CNT_W-1:0] cnt_c;
  logic [15:0]      rec_addr_c;
  line_t            line_new_c;
  line_t            ext_data_c;
  line_t            start_data_c;
  ihex_cmd_t        ext_cmd_c;
  ihex_cmd_t        line_cmd_c;
  ihex_cmd_t        err_cmd_c;

  function automatic ihex_cmd_t make_rec(input logic [7:0] rtype, input logic [15:0] addr,
                                         input logic [CNT_W-1:0] len, input line_t data);
    ihex_cmd_t c;
    c.is_err = 1'b0;
    c.rtype  = rtype;
    c.addr   = addr;
    c.len    = len;
    c.data   = data;
    c.last   = 1'b0;
    return c;
  endfunction

  assign in_tready = (state_r == F_IDLE);
  assign q_push    = (state_r == F_PUSH);
  assign q_cmd     = cmd_r[idx_r];

  // Classify the latched item and work out its commands
  always_comb begin
    line_fill_nxt  = line_fill_r;
    line_start_nxt = line_start_r;
    next_addr_nxt  = next_addr_r;
    window_nxt     = window_r;
    within_run_nxt = within_run_r;
    buf_we         = 1'b0;

    addr_c  = within_run_r ? next_addr_r : {1'b0, it_addr_r};
    unique case (mode_r)
      MODE_16:  over_c = (addr_c[32:16] != '0);
      MODE_SEG: over_c = (addr_c[32:20] != '0);
      default:  over_c = addr_c[32];
    endcase
    win_c   = addr_c[31:16];
    fresh_c = (line_fill_r == '0);
    ext_c   = fresh_c && (mode_r != MODE_16) && (win_c != window_r);
    cnt_c   = {1'b0, line_fill_r} + CNT_W'(1);
    flush_c = (cnt_c == CNT_W'(LINE_BYTES)) || it_end_r || (addr_c[15:0] == 16'hFFFF);
    rec_addr_c = fresh_c ? addr_c[15:0] : line_start_r;

    line_new_c = line_bytes_r;
    line_new_c[line_fill_r] = it_byte_r;

    ext_data_c = '0;
    if (mode_r == MODE_SEG) begin
      ext_data_c[0] = {win_c[3:0], 4'h0};
    end else begin
      ext_data_c[0] = win_c[15:8];
      ext_data_c[1] = win_c[7:0];
    end
    ext_cmd_c = make_rec((mode_r == MODE_SEG) ? REC_EXT_SEG : REC_EXT_LIN, 16'h0000,
                         CNT_W'(2), ext_data_c);

    start_data_c    = '0;
    start_data_c[0] = it_start_r[31:24];
    start_data_c[1] = it_start_r[23:16];
    start_data_c[2] = it_start_r[15:8];
    start_data_c[3] = it_start_r[7:0];

    line_cmd_c       = make_rec(REC_DATA, line_start_r, {1'b0, line_fill_r}, line_bytes_r);
    err_cmd_c        = '0;
    err_cmd_c.is_err = 1'b1;

    cmd0_c = line_cmd_c;
    cmd1_c = err_cmd_c;
    ncmd_c = 2'd0;

    unique case (it_op_r)
      OP_DATA: begin
        if (over_c) begin
          if (!fresh_c) begin
            cmd0_c        = line_cmd_c;
            cmd1_c        = err_cmd_c;
            ncmd_c        = 2'd2;
            line_fill_nxt = '0;
          end else begin
            cmd0_c = err_cmd_c;
            ncmd_c = 2'd1;
          end
        end else begin
          buf_we = 1'b1;
          if (fresh_c) begin
            line_start_nxt = addr_c[15:0];
            if (mode_r == MODE_16) begin
              window_nxt = '0;
            end else if (ext_c) begin
              window_nxt = win_c;
            end
          end
          if (ext_c) begin
            cmd0_c = ext_cmd_c;
            cmd1_c = make_rec(REC_DATA, rec_addr_c, cnt_c, line_new_c);
            ncmd_c = flush_c ? 2'd2 : 2'd1;
          end else begin
            cmd0_c = make_rec(REC_DATA, rec_addr_c, cnt_c, line_new_c);
            ncmd_c = flush_c ? 2'd1 : 2'd0;
          end
          line_fill_nxt = flush_c ? '0 : cnt_c[FILL_W-1:0];
        end
        next_addr_nxt  = addr_c[32] ? addr_c : addr_c + 33'd1;
        within_run_nxt = !it_end_r;
      end
      OP_START_SEG, OP_START_LIN: begin
        cmd0_c = make_rec((it_op_r == OP_START_SEG) ? REC_START_SEG : REC_START_LIN,
                          16'h0000, CNT_W'(4), start_data_c);
        ncmd_c = 2'd1;
      end
      default: begin
        if (!fresh_c) begin
          cmd0_c        = line_cmd_c;
          line_fill_nxt = '0;
        end else begin
          cmd0_c     = make_rec(REC_EOF, 16'h0000, '0, '0);
          window_nxt = '0;
        end
        ncmd_c         = 2'd1;
        within_run_nxt = 1'b0;
      end
    endcase

    // Mark the final command of the item
    if (ncmd_c == 2'd1) begin
      cmd0_c.last = 1'b1;
    end
    if (ncmd_c == 2'd2) begin
      cmd1_c.last = 1'b1;
    end
  end

  // Sequence accept, evaluate and push
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      F_IDLE: begin
        if (in_tvalid) begin
          state_nxt = F_EVAL;
        end
      end
      F_EVAL: begin
        idx_nxt   = 1'b0;
        state_nxt = (ncmd_c == 2'd0) ? F_IDLE : F_PUSH;
      end
      F_PUSH: begin
        if (!q_full) begin
          if ({1'b0, idx_r} + 2'd1 == ncmd_r) begin
            state_nxt = F_IDLE;
          end else begin
            idx_nxt = ~idx_r;
          end
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  // Latch items and pending commands
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      it_op_r    <= in_opcode;
      it_byte_r  <= in_data_byte;
      it_addr_r  <= in_byte_address;
      it_end_r   <= in_run_end;
      it_start_r <= in_start_address;
    end
    if (state_r == F_EVAL) begin
      cmd_r[0] <= cmd0_c;
      cmd_r[1] <= cmd1_c;
      ncmd_r   <= ncmd_c;
    end
    if (state_r == F_EVAL && buf_we) begin
      line_bytes_r[line_fill_r] <= it_byte_r;
    end
  end

  // Control and encoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= F_IDLE;
      idx_r        <= 1'b0;
      mode_r       <= MODE_16;
      line_fill_r  <= '0;
      line_start_r <= '0;
      next_addr_r  <= '0;
      window_r     <= '0;
      within_run_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      if (cfg_we) begin
        mode_r <= cfg_wdata;
      end
      if (state_r == F_EVAL) begin
        line_fill_r  <= line_fill_nxt;
        line_start_r <= line_start_nxt;
        next_addr_r  <= next_addr_nxt;
        window_r     <= window_nxt;
        within_run_r <= within_run_nxt;
      end
    end
  end

endmodule

// ===== rtl/ihex_back.sv =====
// Back end of the Intel HEX encoder: prints queued records one ASCII character
// per cycle, while out_tready is high, into an output register. Uses ihex_pkg.
`timescale 1ns / 1ps

module ihex_back
  import ihex_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  ihex_cmd_t head,
  input  logic      q_empty,
  output logic      q_pop,
  output logic      out_tvalid,
  input  logic      out_tready,
  output logic [7:0] out_char,
  output logic      out_status,
  output logic      out_last
);

  typedef enum logic [2:0] {
    B_START = 3'b001,
    B_HEX   = 3'b010,
    B_LF    = 3'b100
  } back_state_t;

  back_state_t      state_r, state_nxt;
  logic [CNT_W:0]   bi_r, bi_nxt;
  logic             nib_r, nib_nxt;
  logic [7:0]       sum_r, sum_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_char_r, out_char_nxt;
  logic             out_status_r, out_status_nxt;
  logic             out_last_r, out_last_nxt;

  logic             load_ok;
  logic [CNT_W:0]   di_c;
  logic [CNT_W:0]   end_bi_c;
  logic [7:0]       cur_c;

  assign out_tvalid = out_valid_r;
  assign out_char   = out_char_r;
  assign out_status = out_status_r;
  assign out_last   = out_last_r;

  assign load_ok  = !out_valid_r || out_tready;
  assign di_c     = bi_r - (CNT_W+1)'(4);
  assign end_bi_c = {1'b0, head.len} + (CNT_W+1)'(4);

  // Select the byte being printed
  always_comb begin
    if (bi_r == '0) begin
      cur_c = 8'(head.len);
    end else if (bi_r == (CNT_W+1)'(1)) begin
      cur_c = head.addr[15:8];
    end else if (bi_r == (CNT_W+1)'(2)) begin
      cur_c = head.addr[7:0];
    end else if (bi_r == (CNT_W+1)'(3)) begin
      cur_c = head.rtype;
    end else if (bi_r < end_bi_c) begin
      cur_c = head.data[di_c[FILL_W-1:0]];
    end else begin
      cur_c = 8'h00 - sum_r;
    end
  end

  // Walk the record: colon, hex pairs, line feed; an error prints one mark character
  always_comb begin
    state_nxt      = state_r;
    bi_nxt         = bi_r;
    nib_nxt        = nib_r;
    sum_nxt        = sum_r;
    q_pop          = 1'b0;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_char_nxt   = out_char_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    unique case (state_r)
      B_START: begin
        if (!q_empty && load_ok) begin
          out_valid_nxt = 1'b1;
          if (head.is_err) begin
            out_char_nxt   = CHR_ERR;
            out_status_nxt = 1'b1;
            out_last_nxt   = head.last;
            q_pop          = 1'b1;
          end else begin
            out_char_nxt   = CHR_COLON;
            out_status_nxt = 1'b0;
            out_last_nxt   = 1'b0;
            bi_nxt         = '0;
            nib_nxt        = 1'b0;
            sum_nxt        = '0;
            state_nxt      = B_HEX;
          end
        end
      end
      B_HEX: begin
        if (load_ok) begin
          out_valid_nxt  = 1'b1;
          out_char_nxt   = hex_char(nib_r ? cur_c[3:0] : cur_c[7:4]);
          out_status_nxt = 1'b0;
          out_last_nxt   = 1'b0;
          nib_nxt        = ~nib_r;
          if (nib_r) begin
            sum_nxt = sum_r + cur_c;
            bi_nxt  = bi_r + (CNT_W+1)'(1);
            if (bi_r == end_bi_c) begin
              state_nxt = B_LF;
            end
          end
        end
      end
      B_LF: begin
        if (load_ok) begin
          out_valid_nxt  = 1'b1;
          out_char_nxt   = CHR_LF;
          out_status_nxt = 1'b0;
          out_last_nxt   = head.last;
          q_pop          = 1'b1;
          state_nxt      = B_START;
        end
      end
      default: state_nxt = B_START;
    endcase
  end

  // Output register payload
  always_ff @(posedge clk) begin
    out_char_r   <= out_char_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
    bi_r         <= bi_nxt;
    nib_r        <= nib_nxt;
    sum_r        <= sum_nxt;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_START;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/intel_hex_record_encoder_core.sv =====
// Top level of the Intel HEX record encoder: front end, command queue and
// character back end. Depends on ihex_pkg, ihex_front, ihex_cmd_fifo, ihex_back.
`timescale 1ns / 1ps

// Usage:
//   The in_ stream carries commands: data bytes (tuser opcode 0) with their
//   address and a run end flag on tlast, start address commands and end of
//   file. The out_ stream gives the Intel HEX text, one ASCII character per
//   transfer in tdata; tuser flags a dropped out-of-range byte and tlast marks
//   the final character caused by one input transfer.
//   cfg_we with cfg_wdata sets the address mode; write it only while idle.
// Timing:
//   The front end accepts one transfer, decides in F_EVAL, then pushes each
//   record it queues in F_PUSH, waiting while the queue is full, and takes no
//   new transfer before its last record is pushed. Bytes that only fill the
//   line buffer produce no output. The back end prints one character per
//   cycle while out_tready is high; a record of n data bytes is 12 + 2n
//   characters, so a full 16-byte line is 44 characters, about three per byte.
//   The first character passes F_EVAL, F_PUSH, the queue and the output register.
// Reset and stalls:
//   rst_n clears the line buffer count, window and run state and sets 16-bit
//   mode. When out_tready is low the output register holds, the back end
//   stops, the two-entry queue fills and then in_tready drops.

module intel_hex_record_encoder_core
  import ihex_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // [7:0] data_byte, [39:8] byte_address, [71:40] start_address
  input  logic [1:0]  in_tuser,   // [1:0] opcode
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] text_char
  output logic [0:0]  out_tuser,  // [0] status
  output logic        out_tlast
);

  logic      q_push;
  logic      q_full;
  logic      q_pop;
  logic      q_empty;
  ihex_cmd_t q_in;
  ihex_cmd_t q_head;

  ihex_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_tvalid        (in_tvalid),
    .in_tready        (in_tready),
    .in_opcode        (in_tuser),
    .in_data_byte     (in_tdata[7:0]),
    .in_byte_address  (in_tdata[39:8]),
    .in_run_end       (in_tlast),
    .in_start_address (in_tdata[71:40]),
    .q_push           (q_push),
    .q_cmd            (q_in),
    .q_full           (q_full)
  );

  ihex_cmd_fifo u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_in),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  ihex_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_char   (out_tdata),
    .out_status (out_tuser[0]),
    .out_last   (out_tlast)
  );

endmodule
